### hw/rtl/ebaa_pkg.sv
package ebaa_pkg;

  localparam int unsigned LineDepth = 2048;
  localparam int unsigned ColW      = $clog2(LineDepth);
  localparam int unsigned CntW      = 12;
  localparam int unsigned RowW      = 12;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned LumaW     = 10;
  localparam int unsigned ThrW      = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;

  localparam logic [CntW-1:0] MinSize  = CntW'(3);
  localparam logic [CntW-1:0] MaxWidth = CntW'(LineDepth);

  localparam logic [20:0] Recip3 = 21'd683;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth        = 2'd0,
    CfgFrameHeight       = 2'd1,
    CfgContrastThreshold = 2'd2
  } cfg_reg_e;

  // pixel held in the window stage
  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [RgbW-1:0]  rgb;
    logic [LumaW-1:0] luma;
    logic             last_col;
  } pix_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [RgbW-1:0] rgb;
    logic            blended;
  } res_t;

  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
    logic [RgbW-1:0] data;
  } fin_wr_t;

  function automatic logic [LumaW-1:0] luma_of(input logic [RgbW-1:0] rgb);
    logic [17:0] sum;
    sum = 18'(rgb[23:16]) * 18'd299 + 18'(rgb[15:8]) * 18'd587 + 18'(rgb[7:0]) * 18'd114;
    return sum[17:8];
  endfunction

  // floor(x / 3) for x below 768, by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * Recip3;
    return p[18:11];
  endfunction

  function automatic logic [RgbW-1:0] blend3(input logic [RgbW-1:0] c,
                                             input logic [RgbW-1:0] n);
    logic [RgbW-1:0] r;
    logic [9:0]      x;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      x = 10'(c[8*k +: 8]) + {1'b0, n[8*k +: 8], 1'b0};
      r[8*k +: 8] = div3(x);
    end
    return r;
  endfunction

endpackage

### hw/rtl/ebaa_ram.sv
module ebaa_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;
  logic [AddrW-1:0] raddr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // keep the held read word coherent with writes to its address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      raddr_q <= raddr_i;
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end else if (we_i && (waddr_i == raddr_q)) begin
      rdata_q <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ebaa_front.sv
module ebaa_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [ebaa_pkg::RgbW-1:0]  pixel_rgb_i,
  input  logic                       frame_start_i,
  input  logic [ebaa_pkg::CntW-1:0]  frame_width_i,
  input  logic [ebaa_pkg::RowW-1:0]  frame_height_i,
  output logic [ebaa_pkg::ColW-1:0]  rd_col_o,
  output ebaa_pkg::pix_t             pix_o
);
  import ebaa_pkg::*;

  logic [CntW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CntW-1:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic [CntW-1:0] col_base, col_cur;
  logic [RowW-1:0] row_base, row_step;
  pix_t            pix_q, pix_d;

  always_comb begin
    w_eff = frame_width_i;
    if (w_eff < MinSize) begin
      w_eff = MinSize;
    end else if (w_eff > MaxWidth) begin
      w_eff = MaxWidth;
    end
    h_eff = frame_height_i;
    if (h_eff < RowW'(MinSize)) begin
      h_eff = RowW'(MinSize);
    end

    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    // wrap past the row end, then past the frame end
    if (col_base >= w_eff) begin
      col_cur  = '0;
      row_step = row_base + RowW'(1);
    end else begin
      col_cur  = col_base;
      row_step = row_base;
    end
    row_d = (row_step >= h_eff) ? '0 : row_step;
    col_d = col_cur + CntW'(1);

    rd_col_o       = col_cur[ColW-1:0];
    pix_d.col      = col_cur[ColW-1:0];
    pix_d.row      = row_d;
    pix_d.rgb      = pixel_rgb_i;
    pix_d.luma     = luma_of(pixel_rgb_i);
    pix_d.last_col = (col_cur == (w_eff - CntW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

### hw/rtl/ebaa_kernel.sv
module ebaa_kernel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  ebaa_pkg::pix_t               pix_i,
  input  logic [ebaa_pkg::ThrW-1:0]    threshold_i,
  input  logic [2*ebaa_pkg::LumaW-1:0] luma_rd_i,
  input  logic [ebaa_pkg::RgbW-1:0]    centre_rd_i,
  input  logic [ebaa_pkg::RgbW-1:0]    final_rd_i,
  output logic [2*ebaa_pkg::LumaW-1:0] luma_wr_o,
  output ebaa_pkg::fin_wr_t            final_wr_o,
  output logic                         emit_o,
  output ebaa_pkg::res_t               res_o
);
  import ebaa_pkg::*;

  logic [LumaW-1:0] older_d1_q, older_d2_q, cur_d1_q, cur_d2_q;
  logic [RgbW-1:0]  centre_prev_q, up_prev_q, left_q;
  logic             pend_valid_q;
  logic [ColW-1:0]  pend_addr_q;
  logic [RgbW-1:0]  pend_data_q;

  logic             has_centre, full;
  logic [LumaW-1:0] ne, nw, sw, se, mx, mn, spread;
  logic [LumaW:0]   s_bot, s_top, s_lft, s_rgt;
  logic             go_left, go_up, do_blend;
  logic [RgbW-1:0]  up, nb, fin;
  logic             normal_wr;

  always_comb begin
    has_centre = (pix_i.row != '0) && (pix_i.col != '0);
    full       = (pix_i.row > RowW'(1)) && (pix_i.col > ColW'(1));

    nw = older_d2_q;
    ne = luma_rd_i[2*LumaW-1:LumaW];
    sw = cur_d2_q;
    se = pix_i.luma;
    up = (pix_i.col == '0) ? '0 : final_rd_i;

    mx = nw;
    mn = nw;
    if (ne > mx) mx = ne;
    if (sw > mx) mx = sw;
    if (se > mx) mx = se;
    if (ne < mn) mn = ne;
    if (sw < mn) mn = sw;
    if (se < mn) mn = se;
    spread = mx - mn;

    s_bot = {1'b0, sw} + {1'b0, se};
    s_top = {1'b0, nw} + {1'b0, ne};
    s_lft = {1'b0, nw} + {1'b0, sw};
    s_rgt = {1'b0, ne} + {1'b0, se};
    go_left = s_bot < s_top;
    go_up   = s_lft < s_rgt;
    // flat window in both directions: leave the pixel alone
    do_blend = full && (spread >= threshold_i) && !((s_bot == s_top) && (s_lft == s_rgt));

    case ({go_left, go_up})
      2'b11:   nb = up_prev_q;
      2'b10:   nb = left_q;
      2'b01:   nb = up;
      default: nb = centre_prev_q;
    endcase
    fin = do_blend ? blend3(centre_prev_q, nb) : centre_prev_q;

    emit_o        = full;
    res_o.col     = pix_i.col - ColW'(1);
    res_o.row     = pix_i.row - RowW'(1);
    res_o.rgb     = fin;
    res_o.blended = do_blend;

    luma_wr_o = {luma_rd_i[LumaW-1:0], pix_i.luma};

    // right border column goes out one step late, in a free write slot
    normal_wr = step_i && has_centre;
    if (normal_wr) begin
      final_wr_o.en   = 1'b1;
      final_wr_o.addr = pix_i.col - ColW'(1);
      final_wr_o.data = fin;
    end else begin
      final_wr_o.en   = pend_valid_q;
      final_wr_o.addr = pend_addr_q;
      final_wr_o.data = pend_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_d1_q    <= '0;
      older_d2_q    <= '0;
      cur_d1_q      <= '0;
      cur_d2_q      <= '0;
      centre_prev_q <= '0;
      up_prev_q     <= '0;
      left_q        <= '0;
    end else if (step_i) begin
      older_d2_q    <= older_d1_q;
      older_d1_q    <= ne;
      cur_d2_q      <= cur_d1_q;
      cur_d1_q      <= pix_i.luma;
      centre_prev_q <= centre_rd_i;
      up_prev_q     <= up;
      if (has_centre) begin
        left_q <= fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (normal_wr && pix_i.last_col) begin
      pend_valid_q <= 1'b1;
    end else if (!normal_wr) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (normal_wr && pix_i.last_col) begin
      pend_addr_q <= pix_i.col;
      pend_data_q <= centre_rd_i;
    end
  end

endmodule

### hw/rtl/edge_blend_antialias_filter.sv
// Edge blend anti-alias filter: diagonal-contrast blending of an RGB raster stream.
// Input channel: one pixel per request (pixel_rgb_i, frame_start_i) in raster order;
// frame_start_i puts that pixel at column 0, row 0. Frames also wrap on their own.
// Output channel: one request per interior pixel, with its column, row, final
// colour and a flag telling whether it was blended. Border pixels give none.
// The window completes when the pixel below-right of the centre arrives.
// Timing: an accepted request is registered in the window stage, then its result in the
// output register. Throughput: one pixel per cycle while out_ready_i is high, set by the
// single window stage and the one read plus one write port of each line buffer.
// Configuration: write frame_width, frame_height or contrast_threshold through
// the cfg channel (always ready) while the stream is idle.
// Reset: position returns to column 0, row 0 and registers to 640 x 480, threshold 20.
// Line buffers are not cleared; the first frame after reset fills them.
// Stall: while a result waits with out_ready_i low the output register and window
// stage hold; in_ready_o stays high until both are occupied.
module edge_blend_antialias_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ebaa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ebaa_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ebaa_pkg::RgbW-1:0]      pixel_rgb_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ebaa_pkg::ColW-1:0]      out_col_o,
  output logic [ebaa_pkg::RowW-1:0]      out_row_o,
  output logic [ebaa_pkg::RgbW-1:0]      out_rgb_o,
  output logic                           blended_o
);
  import ebaa_pkg::*;

  logic [CntW-1:0] frame_width_q;
  logic [RowW-1:0] frame_height_q;
  logic [ThrW-1:0] contrast_threshold_q;

  logic              accept, adv, step;
  logic              s1_valid_q, out_valid_q;
  res_t              res_q, res;
  logic              emit;
  pix_t              pix;
  logic [ColW-1:0]   rd_col;
  logic [2*LumaW-1:0] luma_rd, luma_wr;
  logic [RgbW-1:0]   centre_rd, final_rd;
  fin_wr_t           final_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q        <= CntW'(640);
      frame_height_q       <= RowW'(480);
      contrast_threshold_q <= ThrW'(20);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrameWidth:        frame_width_q        <= cfg_data_i[CntW-1:0];
        CfgFrameHeight:       frame_height_q       <= cfg_data_i[RowW-1:0];
        CfgContrastThreshold: contrast_threshold_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // advance when the output register is free or drains this cycle
  assign adv        = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= res;
    end
  end

  ebaa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pixel_rgb_i    (pixel_rgb_i),
    .frame_start_i  (frame_start_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .rd_col_o       (rd_col),
    .pix_o          (pix)
  );

  ebaa_ram #(.Width(2*LumaW), .Depth(LineDepth)) u_luma_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (pix.col),
    .wdata_i (luma_wr),
    .re_i    (accept),
    .raddr_i (rd_col),
    .rdata_o (luma_rd)
  );

  ebaa_ram #(.Width(RgbW), .Depth(LineDepth)) u_centre_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (pix.col),
    .wdata_i (pix.rgb),
    .re_i    (accept),
    .raddr_i (rd_col),
    .rdata_o (centre_rd)
  );

  ebaa_ram #(.Width(RgbW), .Depth(LineDepth)) u_final_ram (
    .clk_i   (clk_i),
    .we_i    (final_wr.en),
    .waddr_i (final_wr.addr),
    .wdata_i (final_wr.data),
    .re_i    (accept),
    .raddr_i (rd_col - ColW'(1)),
    .rdata_o (final_rd)
  );

  ebaa_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pix_i       (pix),
    .threshold_i (contrast_threshold_q),
    .luma_rd_i   (luma_rd),
    .centre_rd_i (centre_rd),
    .final_rd_i  (final_rd),
    .luma_wr_o   (luma_wr),
    .final_wr_o  (final_wr),
    .emit_o      (emit),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_col_o   = res_q.col;
  assign out_row_o   = res_q.row;
  assign out_rgb_o   = res_q.rgb;
  assign blended_o   = res_q.blended;

endmodule
